// ===== hw/rtl/cylinder_frame_matrix_top_assert.svh =====
// Assertion macros for the cylinder frame matrix checker
`ifndef CYLINDER_FRAME_MATRIX_TOP_ASSERT_SVH
`define CYLINDER_FRAME_MATRIX_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define CFM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfm assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define CFM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfm assertion failed");

`endif

// ===== hw/rtl/cfm_pkg.sv =====
// Shared widths and pipeline record types for the cylinder frame matrix block
package cfm_pkg;

    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;
    localparam int RAD_W    = 62;   // sum of three squares
    localparam int ROOT_W   = 31;   // floor square root of RAD_W bits
    localparam int NUM_W    = 61;   // magnitude times radius plus rounding
    localparam int DEN_W    = 31;
    localparam int QUO_W    = 32;
    localparam int MAG_W    = 30;   // prescaled magnitude

    // Front section record, one per stage
    typedef struct packed {
        logic [2:0][COORD_W-1:0] s;
        logic [2:0][COORD_W-1:0] d;
        logic [RADIUS_W-1:0]     r;
        logic [2:0][COORD_W-1:0] pm;
        logic [2:0]              ps;
        logic [2:0][COORD_W-1:0] dm;
        logic [2:0]              ds;
        logic [4:0]              psh;
        logic [4:0]              dsh;
        logic [2:0][MAG_W-1:0]   pn;
        logic [2:0][MAG_W-1:0]   dn;
        logic [5:0][61:0]        xp;
        logic [2:0][59:0]        psq;
        logic [RAD_W-1:0]        pss;
        logic [2:0][60:0]        cm;
        logic [2:0]              cs;
        logic                    hi_any;
        logic [4:0]              hi_idx;
        logic [4:0]              lo_idx;
        logic [2:0][MAG_W-1:0]   cn;
        logic [2:0][59:0]        csq;
        logic [RAD_W-1:0]        css;
    } t_front;

    // Carried alongside the square root pipeline
    typedef struct packed {
        logic [2:0][COORD_W-1:0] s;
        logic [2:0][COORD_W-1:0] d;
        logic [RADIUS_W-1:0]     r;
        logic [2:0][MAG_W-1:0]   pn;
        logic [2:0]              ps;
        logic [2:0][MAG_W-1:0]   cn;
        logic [2:0]              cs;
    } t_mid;

    // Carried alongside the divider pipeline
    typedef struct packed {
        logic [2:0][COORD_W-1:0] s;
        logic [2:0][COORD_W-1:0] d;
        logic [2:0]              ps;
        logic [2:0]              cs;
        logic                    pz;
        logic                    sz;
    } t_tail;

    // One finished matrix
    typedef struct packed {
        logic [2:0][COORD_W-1:0] side;
        logic [2:0][COORD_W-1:0] perp;
        logic [2:0][COORD_W-1:0] axis;
        logic [2:0][COORD_W-1:0] origin;
    } t_mat;

endpackage

// ===== hw/rtl/cfm_ifs.sv =====
// Segment request and matrix result channel interfaces
interface cfm_seg_if;
    import cfm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  start_x;
    logic signed [COORD_W-1:0]  start_y;
    logic signed [COORD_W-1:0]  start_z;
    logic signed [COORD_W-1:0]  finish_x;
    logic signed [COORD_W-1:0]  finish_y;
    logic signed [COORD_W-1:0]  finish_z;
    logic [RADIUS_W-1:0]        tube_radius;
    modport source (output valid, start_x, start_y, start_z, finish_x, finish_y,
                    finish_z, tube_radius, input ready);
    modport sink (input valid, start_x, start_y, start_z, finish_x, finish_y,
                  finish_z, tube_radius, output ready);
endinterface

interface cfm_mat_if;
    import cfm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [COORD_W-1:0]  side_x;
    logic signed [COORD_W-1:0]  side_y;
    logic signed [COORD_W-1:0]  side_z;
    logic signed [COORD_W-1:0]  perp_x;
    logic signed [COORD_W-1:0]  perp_y;
    logic signed [COORD_W-1:0]  perp_z;
    logic signed [COORD_W-1:0]  axis_x;
    logic signed [COORD_W-1:0]  axis_y;
    logic signed [COORD_W-1:0]  axis_z;
    logic signed [COORD_W-1:0]  origin_x;
    logic signed [COORD_W-1:0]  origin_y;
    logic signed [COORD_W-1:0]  origin_z;
    modport source (output valid, side_x, side_y, side_z, perp_x, perp_y, perp_z,
                    axis_x, axis_y, axis_z, origin_x, origin_y, origin_z,
                    input ready);
    modport sink (input valid, side_x, side_y, side_z, perp_x, perp_y, perp_z,
                  axis_x, axis_y, axis_z, origin_x, origin_y, origin_z,
                  output ready);
endinterface

// ===== hw/rtl/cfm_isqrt.sv =====
// Pipelined floor square root, one root bit per stage, several lanes in lockstep
module cfm_isqrt #(
    parameter int N     = 2,
    parameter int TAG_W = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  logic                                 i_valid,
    input  logic [N-1:0][cfm_pkg::RAD_W-1:0]     i_rad,
    input  logic [TAG_W-1:0]                     i_tag,
    output logic                                 o_valid,
    output logic [N-1:0][cfm_pkg::ROOT_W-1:0]    o_root,
    output logic [TAG_W-1:0]                     o_tag
);
    import cfm_pkg::*;

    localparam int STG   = ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic [N-1:0][RAD_W-1:0]  r_rad  [STG];
    logic [N-1:0][RAD_W-1:0]  n_rad  [STG];
    logic [N-1:0][REM_W-1:0]  r_rem  [STG];
    logic [N-1:0][REM_W-1:0]  n_rem  [STG];
    logic [N-1:0][ROOT_W-1:0] r_root [STG];
    logic [N-1:0][ROOT_W-1:0] n_root [STG];
    logic [TAG_W-1:0]         r_tag  [STG];
    logic [STG-1:0]           r_v;

    // One restoring step per stage: bring down two radicand bits, try root*4+1
    always_comb begin
        logic [N-1:0][RAD_W-1:0]  p_rad;
        logic [N-1:0][REM_W-1:0]  p_rem;
        logic [N-1:0][ROOT_W-1:0] p_root;
        logic [REM_W-1:0]         rem2;
        logic [REM_W-1:0]         trial;
        for (int k = 0; k < STG; k++) begin
            if (k == 0) begin
                p_rad  = i_rad;
                p_rem  = '0;
                p_root = '0;
            end else begin
                p_rad  = r_rad[k-1];
                p_rem  = r_rem[k-1];
                p_root = r_root[k-1];
            end
            for (int j = 0; j < N; j++) begin
                rem2  = {p_rem[j][ROOT_W-1:0], p_rad[j][RAD_W-1 -: 2]};
                trial = {p_root[j], 2'b01};
                n_rad[k][j] = {p_rad[j][RAD_W-3:0], 2'b00};
                if (rem2 >= trial) begin
                    n_rem[k][j]  = rem2 - trial;
                    n_root[k][j] = {p_root[j][ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem[k][j]  = rem2;
                    n_root[k][j] = {p_root[j][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STG-2:0], i_valid};
        end
    end

    // Stage data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            for (int k = 0; k < STG; k++) begin
                r_rad[k]  <= n_rad[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
            for (int k = 1; k < STG; k++) begin
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_valid = r_v[STG-1];
    assign o_root  = r_root[STG-1];
    assign o_tag   = r_tag[STG-1];

endmodule

// ===== hw/rtl/cfm_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes in lockstep
module cfm_div #(
    parameter int N     = 6,
    parameter int TAG_W = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [N-1:0][cfm_pkg::NUM_W-1:0]    i_num,
    input  logic [N-1:0][cfm_pkg::DEN_W-1:0]    i_den,
    input  logic [TAG_W-1:0]                    i_tag,
    output logic                                o_valid,
    output logic [N-1:0][cfm_pkg::QUO_W-1:0]    o_quo,
    output logic [TAG_W-1:0]                    o_tag
);
    import cfm_pkg::*;

    localparam int STG = QUO_W;

    logic [N-1:0][QUO_W-1:0] r_rem [STG];
    logic [N-1:0][QUO_W-1:0] n_rem [STG];
    logic [N-1:0][QUO_W-1:0] r_lo  [STG];
    logic [N-1:0][QUO_W-1:0] n_lo  [STG];
    logic [N-1:0][QUO_W-1:0] r_quo [STG];
    logic [N-1:0][QUO_W-1:0] n_quo [STG];
    logic [N-1:0][DEN_W-1:0] r_den [STG];
    logic [TAG_W-1:0]        r_tag [STG];
    logic [STG-1:0]          r_v;

    // Upper numerator bits start as the partial remainder (they stay below the divisor)
    always_comb begin
        logic [N-1:0][QUO_W-1:0] p_rem;
        logic [N-1:0][QUO_W-1:0] p_lo;
        logic [N-1:0][QUO_W-1:0] p_quo;
        logic [N-1:0][DEN_W-1:0] p_den;
        logic [QUO_W-1:0]        t;
        for (int k = 0; k < STG; k++) begin
            if (k == 0) begin
                for (int j = 0; j < N; j++) begin
                    p_rem[j] = QUO_W'(i_num[j][NUM_W-1:QUO_W]);
                    p_lo[j]  = i_num[j][QUO_W-1:0];
                end
                p_quo = '0;
                p_den = i_den;
            end else begin
                p_rem = r_rem[k-1];
                p_lo  = r_lo[k-1];
                p_quo = r_quo[k-1];
                p_den = r_den[k-1];
            end
            for (int j = 0; j < N; j++) begin
                t = {p_rem[j][QUO_W-2:0], p_lo[j][QUO_W-1]};
                n_lo[k][j] = {p_lo[j][QUO_W-2:0], 1'b0};
                if (t >= QUO_W'(p_den[j])) begin
                    n_rem[k][j] = t - QUO_W'(p_den[j]);
                    n_quo[k][j] = {p_quo[j][QUO_W-2:0], 1'b1};
                end else begin
                    n_rem[k][j] = t;
                    n_quo[k][j] = {p_quo[j][QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[STG-2:0], i_valid};
        end
    end

    // Stage data
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0] <= i_den;
            r_tag[0] <= i_tag;
            for (int k = 0; k < STG; k++) begin
                r_rem[k] <= n_rem[k];
                r_lo[k]  <= n_lo[k];
                r_quo[k] <= n_quo[k];
            end
            for (int k = 1; k < STG; k++) begin
                r_den[k] <= r_den[k-1];
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_valid = r_v[STG-1];
    assign o_quo   = r_quo[STG-1];
    assign o_tag   = r_tag[STG-1];

endmodule

// ===== hw/rtl/cylinder_frame_matrix_top.sv =====
// Cylinder instance matrix: segment and radius in, twelve matrix entries out
//
//  channel  | dir | modport          | carries
//  ---------+-----+------------------+--------------------------------------
//  i_seg    | in  | cfm_seg_if.sink  | start xyz, finish xyz, tube_radius
//  o_mat    | out | cfm_mat_if.source| side, perp, axis, origin columns
//
// One request enters every cycle unless a result waits in the skid register.
// The path holds 76 register stages, the first loaded at the accepting edge: 10 front
// stages (prescale, cross product, squares), 31 square root stages, 2 numerator
// stages, 32 divider stages and the output register.
// Reset clears only valid bits and the output/skid flags.
// When the output stalls, the next result lands in a skid register and only
// then does the pipeline freeze; nothing is dropped or repeated.
module cylinder_frame_matrix_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cfm_seg_if.sink    i_seg,
    cfm_mat_if.source  o_mat
);
    import cfm_pkg::*;

    localparam int NF = 10;

    // Highest set bit of a 32-bit word, zero for zero
    function automatic logic [4:0] msb32(input logic [31:0] v);
        logic [4:0] idx;
        idx = '0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) idx = 5'(i);
        end
        return idx;
    endfunction

    // Shift so that the top bit lands on bit 29
    function automatic logic [MAG_W-1:0] norm32(input logic [31:0] m, input logic [4:0] idx);
        logic [31:0] t;
        if (idx > 5'd29) t = m >> (idx - 5'd29);
        else             t = m << (5'd29 - idx);
        return t[MAG_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] norm61(input logic [60:0] m, input logic [5:0] idx);
        logic [60:0] t;
        if (idx > 6'd29) t = m >> (idx - 6'd29);
        else             t = m << (6'd29 - idx);
        return t[MAG_W-1:0];
    endfunction

    logic   w_en;
    t_front r_f [NF];
    t_front n_f [NF];
    logic [NF-1:0] r_fv;

    // Front stages
    always_comb begin
        logic [2:0][COORD_W-1:0] in_s;
        logic [2:0][COORD_W-1:0] in_e;
        logic signed [COORD_W:0] diff;
        logic signed [MAG_W:0]   a [3];
        logic signed [MAG_W:0]   b [3];
        logic signed [61:0]      c;
        logic signed [61:0]      cneg;
        logic [60:0]             cor;
        in_s = {i_seg.start_z, i_seg.start_y, i_seg.start_x};
        in_e = {i_seg.finish_z, i_seg.finish_y, i_seg.finish_x};

        // stage 0: saturated axis
        n_f[0]   = '0;
        n_f[0].r = i_seg.tube_radius;
        for (int i = 0; i < 3; i++) begin
            n_f[0].s[i] = in_s[i];
            diff = $signed({in_e[i][COORD_W-1], in_e[i]})
                 - $signed({in_s[i][COORD_W-1], in_s[i]});
            if (diff[COORD_W] != diff[COORD_W-1])
                n_f[0].d[i] = diff[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                            : {1'b0, {(COORD_W-1){1'b1}}};
            else
                n_f[0].d[i] = diff[COORD_W-1:0];
        end

        // stage 1: magnitudes and perpendicular choice
        n_f[1] = r_f[0];
        for (int i = 0; i < 3; i++) begin
            n_f[1].ds[i] = r_f[0].d[i][COORD_W-1];
            n_f[1].dm[i] = r_f[0].d[i][COORD_W-1] ? (~r_f[0].d[i] + 1'b1) : r_f[0].d[i];
        end
        if (n_f[1].dm[1] > n_f[1].dm[2]) begin
            n_f[1].pm[0] = n_f[1].dm[1]; n_f[1].ps[0] = !n_f[1].ds[1];
            n_f[1].pm[1] = n_f[1].dm[0]; n_f[1].ps[1] = n_f[1].ds[0];
            n_f[1].pm[2] = '0;           n_f[1].ps[2] = 1'b0;
        end else begin
            n_f[1].pm[0] = n_f[1].dm[2]; n_f[1].ps[0] = !n_f[1].ds[2];
            n_f[1].pm[1] = '0;           n_f[1].ps[1] = 1'b0;
            n_f[1].pm[2] = n_f[1].dm[0]; n_f[1].ps[2] = n_f[1].ds[0];
        end

        // stage 2: prescale shift amounts
        n_f[2]     = r_f[1];
        n_f[2].psh = msb32(r_f[1].pm[0] | r_f[1].pm[1] | r_f[1].pm[2]);
        n_f[2].dsh = msb32(r_f[1].dm[0] | r_f[1].dm[1] | r_f[1].dm[2]);

        // stage 3: prescaled perpendicular and axis
        n_f[3] = r_f[2];
        for (int i = 0; i < 3; i++) begin
            n_f[3].pn[i] = norm32(r_f[2].pm[i], r_f[2].psh);
            n_f[3].dn[i] = norm32(r_f[2].dm[i], r_f[2].dsh);
        end

        // stage 4: cross-product terms and perpendicular squares
        n_f[4] = r_f[3];
        for (int i = 0; i < 3; i++) begin
            a[i] = r_f[3].ps[i] ? -$signed({1'b0, r_f[3].pn[i]}) : $signed({1'b0, r_f[3].pn[i]});
            b[i] = r_f[3].ds[i] ? -$signed({1'b0, r_f[3].dn[i]}) : $signed({1'b0, r_f[3].dn[i]});
            n_f[4].psq[i] = r_f[3].pn[i] * r_f[3].pn[i];
        end
        n_f[4].xp[0] = a[1] * b[2];
        n_f[4].xp[1] = a[2] * b[1];
        n_f[4].xp[2] = a[2] * b[0];
        n_f[4].xp[3] = a[0] * b[2];
        n_f[4].xp[4] = a[0] * b[1];
        n_f[4].xp[5] = a[1] * b[0];

        // stage 5: cross product and perpendicular sum of squares
        n_f[5] = r_f[4];
        for (int i = 0; i < 3; i++) begin
            c    = $signed(r_f[4].xp[2*i]) - $signed(r_f[4].xp[2*i+1]);
            cneg = -c;
            n_f[5].cs[i] = c[61];
            n_f[5].cm[i] = c[61] ? cneg[60:0] : c[60:0];
        end
        n_f[5].pss = {2'b00, r_f[4].psq[0]} + {2'b00, r_f[4].psq[1]} + {2'b00, r_f[4].psq[2]};

        // stage 6: top bit of the cross product, split in halves
        n_f[6]        = r_f[5];
        cor           = r_f[5].cm[0] | r_f[5].cm[1] | r_f[5].cm[2];
        n_f[6].hi_any = |cor[60:30];
        n_f[6].hi_idx = msb32({1'b0, cor[60:30]});
        n_f[6].lo_idx = msb32({2'b00, cor[29:0]});

        // stage 7: prescaled cross product
        n_f[7] = r_f[6];
        for (int i = 0; i < 3; i++) begin
            n_f[7].cn[i] = norm61(r_f[6].cm[i],
                                  r_f[6].hi_any ? (6'd30 + 6'(r_f[6].hi_idx))
                                                : 6'(r_f[6].lo_idx));
        end

        // stage 8: cross squares
        n_f[8] = r_f[7];
        for (int i = 0; i < 3; i++) begin
            n_f[8].csq[i] = r_f[7].cn[i] * r_f[7].cn[i];
        end

        // stage 9: cross sum of squares
        n_f[9]     = r_f[8];
        n_f[9].css = {2'b00, r_f[8].csq[0]} + {2'b00, r_f[8].csq[1]} + {2'b00, r_f[8].csq[2]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (w_en) begin
            r_fv <= {r_fv[NF-2:0], i_seg.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f <= n_f;
        end
    end

    // Square roots of both sums
    t_mid w_mid_in;
    t_mid w_mid_out;
    logic w_sq_v;
    logic [1:0][ROOT_W-1:0] w_root;

    always_comb begin
        w_mid_in.s  = r_f[NF-1].s;
        w_mid_in.d  = r_f[NF-1].d;
        w_mid_in.r  = r_f[NF-1].r;
        w_mid_in.pn = r_f[NF-1].pn;
        w_mid_in.ps = r_f[NF-1].ps;
        w_mid_in.cn = r_f[NF-1].cn;
        w_mid_in.cs = r_f[NF-1].cs;
    end

    cfm_isqrt #(.N(2), .TAG_W($bits(t_mid))) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_fv[NF-1]),
        .i_rad   ({r_f[NF-1].css, r_f[NF-1].pss}),
        .i_tag   (w_mid_in),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_tag   (w_mid_out)
    );

    // Numerators: magnitude times radius, then plus half the root
    t_tail                   r_t0, r_t1, n_t0;
    logic [5:0][NUM_W-1:0]   r_prod, n_prod, r_num, n_num;
    logic [1:0][ROOT_W-1:0]  r_q0, r_q1;
    logic                    r_v0, r_v1;
    logic [5:0][DEN_W-1:0]   w_den;

    always_comb begin
        n_t0.s  = w_mid_out.s;
        n_t0.d  = w_mid_out.d;
        n_t0.ps = w_mid_out.ps;
        n_t0.cs = w_mid_out.cs;
        n_t0.pz = (w_root[0] == '0);
        n_t0.sz = (w_root[1] == '0);
        // lanes 0..2 side, 3..5 perp
        for (int i = 0; i < 3; i++) begin
            n_prod[i]   = w_mid_out.cn[i] * w_mid_out.r;
            n_prod[i+3] = w_mid_out.pn[i] * w_mid_out.r;
        end
        for (int i = 0; i < 3; i++) begin
            n_num[i]   = r_prod[i]   + NUM_W'(r_q0[1] >> 1);
            n_num[i+3] = r_prod[i+3] + NUM_W'(r_q0[0] >> 1);
            w_den[i]   = r_q1[1];
            w_den[i+3] = r_q1[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= w_sq_v;
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t0   <= n_t0;
            r_prod <= n_prod;
            r_q0   <= w_root;
            r_t1   <= r_t0;
            r_num  <= n_num;
            r_q1   <= r_q0;
        end
    end

    // Six divisions in lockstep
    t_tail                  w_tail;
    logic                   w_dv;
    logic [5:0][QUO_W-1:0]  w_quo;

    cfm_div #(.N(6), .TAG_W($bits(t_tail))) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v1),
        .i_num   (r_num),
        .i_den   (w_den),
        .i_tag   (r_t1),
        .o_valid (w_dv),
        .o_quo   (w_quo),
        .o_tag   (w_tail)
    );

    // Sign, zero-length and clamp
    t_mat w_fin;
    always_comb begin
        logic [QUO_W-1:0] res;
        logic             neg;
        logic             zero;
        w_fin.axis   = w_tail.d;
        w_fin.origin = w_tail.s;
        for (int i = 0; i < 6; i++) begin
            neg  = (i < 3) ? w_tail.cs[i % 3] : w_tail.ps[i % 3];
            zero = (i < 3) ? w_tail.sz : w_tail.pz;
            res  = w_quo[i][QUO_W-1] ? {1'b0, {(QUO_W-1){1'b1}}} : w_quo[i];
            if (zero) res = '0;
            else if (neg) res = -res;
            if (i < 3) w_fin.side[i % 3] = res;
            else       w_fin.perp[i % 3] = res;
        end
    end

    // Output register with skid
    t_mat r_o, r_s;
    logic r_ov, r_sv;

    assign w_en = !r_sv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (o_mat.ready) r_sv <= 1'b0;
        end else if (w_dv) begin
            if (r_ov && !o_mat.ready) r_sv <= 1'b1;
            r_ov <= 1'b1;
        end else if (o_mat.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sv) begin
            if (o_mat.ready) r_o <= r_s;
        end else if (w_dv) begin
            if (!r_ov || o_mat.ready) r_o <= w_fin;
            else                      r_s <= w_fin;
        end
    end

    assign i_seg.ready    = w_en;
    assign o_mat.valid    = r_ov;
    assign o_mat.side_x   = r_o.side[0];
    assign o_mat.side_y   = r_o.side[1];
    assign o_mat.side_z   = r_o.side[2];
    assign o_mat.perp_x   = r_o.perp[0];
    assign o_mat.perp_y   = r_o.perp[1];
    assign o_mat.perp_z   = r_o.perp[2];
    assign o_mat.axis_x   = r_o.axis[0];
    assign o_mat.axis_y   = r_o.axis[1];
    assign o_mat.axis_z   = r_o.axis[2];
    assign o_mat.origin_x = r_o.origin[0];
    assign o_mat.origin_y = r_o.origin[1];
    assign o_mat.origin_z = r_o.origin[2];

endmodule

// ===== hw/rtl/cfm_checker.sv =====
// Port-level checks for the cylinder frame matrix top level, with its bind
`include "cylinder_frame_matrix_top_assert.svh"

module cfm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_side_x,
    input logic [31:0] i_axis_x,
    input logic [31:0] i_perp_y,
    input logic [31:0] i_perp_z
);
    logic [7:0] r_cnt;
    logic [7:0] n_cnt;

    // Requests accepted but not yet delivered
    always_comb begin
        n_cnt = r_cnt;
        if (i_in_valid && i_in_ready)   n_cnt = n_cnt + 8'd1;
        if (i_out_valid && i_out_ready) n_cnt = n_cnt - 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    `CFM_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_side_x) && $stable(i_axis_x))
    `CFM_ASSERT_NOW(a_no_extra, i_clk, i_rst_n, i_out_valid && i_out_ready, r_cnt != 8'd0)
    `CFM_ASSERT_NOW(a_perp_zero, i_clk, i_rst_n, i_out_valid, i_perp_y == 32'd0 || i_perp_z == 32'd0)
    `CFM_ASSERT_NOW(a_ready_free, i_clk, i_rst_n, !i_out_valid, i_in_ready)

endmodule

bind cylinder_frame_matrix_top cfm_checker u_cfm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_seg.valid),
    .i_in_ready  (i_seg.ready),
    .i_out_valid (o_mat.valid),
    .i_out_ready (o_mat.ready),
    .i_side_x    (o_mat.side_x),
    .i_axis_x    (o_mat.axis_x),
    .i_perp_y    (o_mat.perp_y),
    .i_perp_z    (o_mat.perp_z)
);

// ===== sim/tb_cfm_ifs.sv =====
// Note: the channel interfaces come from the RTL (cfm_ifs.sv); this file holds shared testbench types
package tb_cfm_pkg;
    import cfm_pkg::*;

    // One segment request as driven on the input channel
    typedef struct packed {
        logic signed [COORD_W-1:0] sx, sy, sz;
        logic signed [COORD_W-1:0] fx, fy, fz;
        logic [RADIUS_W-1:0]       rad;
    } t_seg;

    // One expected matrix in output field order
    typedef struct packed {
        logic signed [COORD_W-1:0] side_x, side_y, side_z;
        logic signed [COORD_W-1:0] perp_x, perp_y, perp_z;
        logic signed [COORD_W-1:0] axis_x, axis_y, axis_z;
        logic signed [COORD_W-1:0] org_x, org_y, org_z;
    } t_frame;
endpackage

// ===== sim/tb.sv =====
// Self-checking testbench for the cylinder frame matrix pipeline
module tb;
    import cfm_pkg::*;
    import tb_cfm_pkg::*;

    localparam int LATENCY   = 76;
    localparam int MAX_CYCLE = 400000;
    localparam int N_RANDOM  = 1200;

    typedef longint signed t_vec [3];

    // Matrix predictor and the queue of frames still owed by the block
    class frame_board;
        t_frame owed [$];
        int     errors;

        static function longint unsigned mag(longint signed v);
            return v < 0 ? longint'(-v) : longint'(v);
        endfunction

        static function longint signed clamp32(longint signed v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Shift all magnitudes together so the largest sits in [2^29, 2^30)
        static function t_vec prescale(t_vec v);
            longint unsigned m [3];
            longint unsigned top, u;
            int rs, ls;
            t_vec o;
            rs = 0;
            ls = 0;
            for (int i = 0; i < 3; i++) m[i] = mag(v[i]);
            top = m[0];
            if (m[1] > top) top = m[1];
            if (m[2] > top) top = m[2];
            if (top != 0) begin
                while (top >= (64'd1 << 30)) begin top >>= 1; rs++; end
                while (top < (64'd1 << 29)) begin top <<= 1; ls++; end
            end
            for (int i = 0; i < 3; i++) begin
                u = (top == 0) ? 0 : ((m[i] >> rs) << ls);
                o[i] = v[i] < 0 ? -longint'(u) : longint'(u);
            end
            return o;
        endfunction

        static function longint unsigned root(longint unsigned n);
            longint unsigned res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n -= res + b;
                    res = (res >> 1) + b;
                end else begin
                    res >>= 1;
                end
                b >>= 2;
            end
            return res;
        endfunction

        // Unit vector scaled by radius, rounded to nearest
        static function t_vec scaled_unit(t_vec v, longint unsigned r);
            t_vec p, o;
            longint unsigned sum, q, m, res;
            p = prescale(v);
            sum = 0;
            for (int i = 0; i < 3; i++) sum += mag(p[i]) * mag(p[i]);
            q = root(sum);
            for (int i = 0; i < 3; i++) begin
                if (q == 0) begin
                    o[i] = 0;
                end else begin
                    m = mag(p[i]);
                    res = (m * r + (q >> 1)) / q;
                    o[i] = clamp32(p[i] < 0 ? -longint'(res) : longint'(res));
                end
            end
            return o;
        endfunction

        function void note_segment(t_seg g);
            t_vec s, d, p, pn, dn, c, pv, sv;
            t_frame f;
            s = '{longint'(g.sx), longint'(g.sy), longint'(g.sz)};
            d[0] = clamp32(longint'(g.fx) - s[0]);
            d[1] = clamp32(longint'(g.fy) - s[1]);
            d[2] = clamp32(longint'(g.fz) - s[2]);
            // perpendicular: swap out the larger of |y| and |z|
            if (mag(d[1]) > mag(d[2])) p = '{-d[1], d[0], 0};
            else p = '{-d[2], 0, d[0]};
            pn = prescale(p);
            dn = prescale(d);
            c[0] = pn[1] * dn[2] - pn[2] * dn[1];
            c[1] = pn[2] * dn[0] - pn[0] * dn[2];
            c[2] = pn[0] * dn[1] - pn[1] * dn[0];
            pv = scaled_unit(p, longint'(g.rad));
            sv = scaled_unit(c, longint'(g.rad));
            f.side_x = sv[0][31:0]; f.side_y = sv[1][31:0]; f.side_z = sv[2][31:0];
            f.perp_x = pv[0][31:0]; f.perp_y = pv[1][31:0]; f.perp_z = pv[2][31:0];
            f.axis_x = d[0][31:0];  f.axis_y = d[1][31:0];  f.axis_z = d[2][31:0];
            f.org_x = g.sx; f.org_y = g.sy; f.org_z = g.sz;
            owed.push_back(f);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            errors++;
        endtask

        task check_frame(t_frame g);
            t_frame w;
            if (owed.size() == 0) begin
                report("unexpected matrix", g.side_x, 'x);
                return;
            end
            w = owed.pop_front();
            if (g.side_x !== w.side_x) report("side_x", g.side_x, w.side_x);
            if (g.side_y !== w.side_y) report("side_y", g.side_y, w.side_y);
            if (g.side_z !== w.side_z) report("side_z", g.side_z, w.side_z);
            if (g.perp_x !== w.perp_x) report("perp_x", g.perp_x, w.perp_x);
            if (g.perp_y !== w.perp_y) report("perp_y", g.perp_y, w.perp_y);
            if (g.perp_z !== w.perp_z) report("perp_z", g.perp_z, w.perp_z);
            if (g.axis_x !== w.axis_x) report("axis_x", g.axis_x, w.axis_x);
            if (g.axis_y !== w.axis_y) report("axis_y", g.axis_y, w.axis_y);
            if (g.axis_z !== w.axis_z) report("axis_z", g.axis_z, w.axis_z);
            if (g.org_x !== w.org_x) report("origin_x", g.org_x, w.org_x);
            if (g.org_y !== w.org_y) report("origin_y", g.org_y, w.org_y);
            if (g.org_z !== w.org_z) report("origin_z", g.org_z, w.org_z);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    cfm_seg_if seg ();
    cfm_mat_if mat ();
    frame_board board = new();
    int  cycle = 0;
    bit  calm = 1'b0;       // no idling in the last part
    bit  hold_out = 1'b0;   // long receiver hold-off
    bit  sent_all = 1'b0;

    cylinder_frame_matrix_top i_dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_seg(seg), .o_mat(mat));

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        seg.valid = 1'b0;
        seg.start_x = '0; seg.start_y = '0; seg.start_z = '0;
        seg.finish_x = '0; seg.finish_y = '0; seg.finish_z = '0;
        seg.tube_radius = '0;
        mat.ready = 1'b0;
    end

    // Timeout watchdog
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYCLE) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random ready bursts, one long hold-off
    initial begin
        int n;
        bit rdy;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_out) begin
                mat.ready <= 1'b0;
                @(posedge i_clk iff !hold_out);
            end else if (calm) begin
                mat.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                rdy = $urandom_range(0, 2) != 0;
                n = $urandom_range(1, 16);
                mat.ready <= rdy;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Sample results on the clock edge
    always @(posedge i_clk) begin
        t_frame g;
        if (i_rst_n && mat.valid && mat.ready) begin
            g = {mat.side_x, mat.side_y, mat.side_z, mat.perp_x, mat.perp_y, mat.perp_z,
                 mat.axis_x, mat.axis_y, mat.axis_z, mat.origin_x, mat.origin_y,
                 mat.origin_z};
            board.check_frame(g);
        end
    end

    // Offer one request and wait until it is taken
    task send_segment(t_seg g);
        seg.valid <= 1'b1;
        seg.start_x <= g.sx; seg.start_y <= g.sy; seg.start_z <= g.sz;
        seg.finish_x <= g.fx; seg.finish_y <= g.fy; seg.finish_z <= g.fz;
        seg.tube_radius <= g.rad;
        @(posedge i_clk);
        while (!seg.ready) @(posedge i_clk);
        board.note_segment(g);
    endtask

    task idle_sender();
        if (!calm && $urandom_range(0, 5) == 0) begin
            seg.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 4) - 2;
            3: return {{16{$urandom_range(0, 1) == 1}}, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic t_seg random_segment();
        t_seg g;
        g.sx = pick_coord(); g.sy = pick_coord(); g.sz = pick_coord();
        // often a short axis near the start point
        if ($urandom_range(0, 1) == 1) begin
            g.fx = g.sx + ($urandom_range(0, 3) == 0 ? pick_coord() : 32'($urandom_range(0, 200000)) - 100000);
            g.fy = g.sy + ($urandom_range(0, 3) == 0 ? pick_coord() : 32'($urandom_range(0, 200000)) - 100000);
            g.fz = g.sz + ($urandom_range(0, 3) == 0 ? pick_coord() : 32'($urandom_range(0, 200000)) - 100000);
        end else begin
            g.fx = pick_coord(); g.fy = pick_coord(); g.fz = pick_coord();
        end
        case ($urandom_range(0, 4))
            0: g.rad = '0;
            1: g.rad = '1;
            2: g.rad = 31'($urandom_range(0, 1 << 20));
            default: g.rad = 31'($urandom);
        endcase
        return g;
    endfunction

    // Stimulus: directed cases, random with a long stall, drain pause, calm tail
    initial begin
        t_seg g;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // zero-length axis, zero radius, largest radius, saturating axis
        send_segment('{32'd5, 32'd6, 32'd7, 32'd5, 32'd6, 32'd7, 31'h7fff_ffff});
        send_segment('{32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0, 31'd0});
        send_segment('{32'd0, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'd0, 31'h7fff_ffff});
        send_segment('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff});
        send_segment('{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                       32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h0001_0000});
        // |y| > |z|, |y| == |z|, |y| < |z|
        send_segment('{32'd0, 32'd0, 32'd0, 32'd3, 32'd9, 32'd2, 31'h0002_0000});
        send_segment('{32'd0, 32'd0, 32'd0, 32'd3, -32'd9, 32'd9, 31'h0002_0000});
        send_segment('{32'd0, 32'd0, 32'd0, -32'd3, 32'd2, -32'd9, 31'h0002_0000});
        send_segment('{32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd2, 31'd1});
        send_segment('{32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 31'h5555_5555});
        send_segment('{32'hffff_ffff, 32'h1234_5678, 32'h8765_4321,
                       32'h0000_0001, 32'hedcb_a987, 32'h789a_bcde, 31'h2aaa_aaaa});
        for (int k = 0; k < N_RANDOM; k++) begin
            if (k == 300) fork
                begin
                    hold_out = 1'b1;
                    repeat (300) @(posedge i_clk);
                    hold_out = 1'b0;
                end
            join_none
            if (k == 700) begin
                seg.valid <= 1'b0;
                wait (board.owed.size() == 0);
                @(posedge i_clk);
            end
            if (k == N_RANDOM - 150) calm = 1'b1;
            idle_sender();
            send_segment(random_segment());
        end
        seg.valid <= 1'b0;
        sent_all = 1'b1;
    end

    // End of run
    initial begin
        wait (sent_all);
        wait (board.owed.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
